>>> hw/rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Shared constants and types for the sorted score table: table geometry,
// field widths, request modes, entry layout and controller states.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int CAPACITY   = 16;
  localparam int NAME_CHARS = 3;

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int SCORE_W = 32;
  localparam int INIT_W  = 24;
  localparam int RANK_W  = 4;
  localparam int MODE_W  = 2;

  // Only the low NAME_CHARS characters of the initials are kept.
  localparam int NAME_BITS = (NAME_CHARS * 8 < INIT_W) ? NAME_CHARS * 8 : INIT_W;
  localparam logic [INIT_W-1:0] NAME_MASK = {INIT_W{1'b1}} >> (INIT_W - NAME_BITS);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_DUMP   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [INIT_W-1:0]         initials;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_FULL,
    ST_INS_STEP,
    ST_INS_CMP,
    ST_DUMP_LOAD,
    ST_DUMP_WAIT
  } state_t;

endpackage

>>> hw/rtl/sst_ram.sv
// ----------------------------------------------------------------------------
// sst_ram
// Generic single-clock RAM with one write port and one read port. The read
// data is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/sorted_score_table_top.sv
// ----------------------------------------------------------------------------
// sorted_score_table_top
// High-score table kept in descending score order in one entry RAM.
// Insert walks from the bottom of the table upward; each slot moved takes a
// RAM read, then a compare and write back.
// Dump delivers CAPACITY results, each held while out_stall is high. Clear
// and unused modes return straight to idle. One request is worked at a time.
// Reset empties the table; the RAM contents are left as they are.
// ----------------------------------------------------------------------------
module sorted_score_table_top
  import sst_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [MODE_W-1:0]         in_mode,
  input  logic signed [SCORE_W-1:0] in_score,
  input  logic [INIT_W-1:0]         in_initials,

  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [RANK_W-1:0]         out_rank,
  output logic signed [SCORE_W-1:0] out_entry_score,
  output logic [INIT_W-1:0]         out_entry_initials,
  output logic                      out_slot_valid,
  output logic                      out_last
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  entry_t                    new_r, new_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [RANK_W-1:0]         out_rank_r, out_rank_nxt;
  logic signed [SCORE_W-1:0] out_score_r, out_score_nxt;
  logic [INIT_W-1:0]         out_init_r, out_init_nxt;
  logic                      out_slot_valid_r, out_slot_valid_nxt;
  logic                      out_last_r, out_last_nxt;

  logic                      ram_wr_en;
  logic [IDX_W-1:0]          ram_wr_addr;
  entry_t                    ram_wr_data;
  logic [IDX_W-1:0]          ram_rd_addr;
  entry_t                    ram_rd_data;

  logic                      in_fire;
  logic                      out_fire;
  logic                      rd_ranks_ahead;
  logic                      slot_used;

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;

  // An entry with an equal or higher score stays above the new one.
  assign rd_ranks_ahead = (ram_rd_data.score >= new_r.score);
  assign slot_used      = ({1'b0, idx_r} < count_r);

  sst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (mode_t'(in_mode))
            MODE_INSERT: state_nxt = (count_r == FULL_CNT) ? ST_INS_FULL : ST_INS_STEP;
            MODE_DUMP:   state_nxt = ST_DUMP_LOAD;
            MODE_CLEAR,
            MODE_NONE:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_INS_FULL:  state_nxt = rd_ranks_ahead ? ST_IDLE : ST_INS_STEP;
      ST_INS_STEP:  state_nxt = (idx_r == '0) ? ST_IDLE : ST_INS_CMP;
      ST_INS_CMP:   state_nxt = rd_ranks_ahead ? ST_IDLE : ST_INS_STEP;
      ST_DUMP_LOAD: state_nxt = ST_DUMP_WAIT;
      ST_DUMP_WAIT: begin
        if (out_fire) begin
          state_nxt = out_last_r ? ST_IDLE : ST_DUMP_LOAD;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    count_nxt          = count_r;
    idx_nxt            = idx_r;
    new_nxt            = new_r;
    out_valid_nxt      = out_valid_r;
    out_rank_nxt       = out_rank_r;
    out_score_nxt      = out_score_r;
    out_init_nxt       = out_init_r;
    out_slot_valid_nxt = out_slot_valid_r;
    out_last_nxt       = out_last_r;
    ram_wr_en          = 1'b0;
    ram_wr_addr        = idx_r;
    ram_wr_data        = new_r;
    ram_rd_addr        = idx_r - 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        ram_rd_addr = LAST_IDX;
        if (in_fire) begin
          new_nxt.score    = in_score;
          new_nxt.initials = in_initials & NAME_MASK;
          unique case (mode_t'(in_mode))
            MODE_INSERT: begin
              // Start at the first free slot, or the bottom slot when full.
              idx_nxt = (count_r == FULL_CNT) ? LAST_IDX : count_r[IDX_W-1:0];
            end
            MODE_CLEAR: count_nxt = '0;
            MODE_DUMP: begin
              idx_nxt     = '0;
              ram_rd_addr = '0;
            end
            MODE_NONE: ;
          endcase
        end
      end
      ST_INS_FULL: ;
      ST_INS_STEP: begin
        if (idx_r == '0) begin
          ram_wr_en = 1'b1;
          if (count_r != FULL_CNT) begin
            count_nxt = count_r + 1'b1;
          end
        end
      end
      ST_INS_CMP: begin
        ram_wr_en = 1'b1;
        if (rd_ranks_ahead) begin
          if (count_r != FULL_CNT) begin
            count_nxt = count_r + 1'b1;
          end
        end else begin
          // Move the lower-scoring entry down one slot and keep climbing.
          ram_wr_data = ram_rd_data;
          idx_nxt     = idx_r - 1'b1;
        end
      end
      ST_DUMP_LOAD: begin
        out_valid_nxt      = 1'b1;
        out_rank_nxt       = RANK_W'(idx_r);
        out_slot_valid_nxt = slot_used;
        out_score_nxt      = slot_used ? ram_rd_data.score : '0;
        out_init_nxt       = slot_used ? ram_rd_data.initials : '0;
        out_last_nxt       = (idx_r == LAST_IDX);
      end
      ST_DUMP_WAIT: begin
        ram_rd_addr = idx_r + 1'b1;
        if (out_fire) begin
          out_valid_nxt = 1'b0;
          idx_nxt       = idx_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r            <= idx_nxt;
    new_r            <= new_nxt;
    out_rank_r       <= out_rank_nxt;
    out_score_r      <= out_score_nxt;
    out_init_r       <= out_init_nxt;
    out_slot_valid_r <= out_slot_valid_nxt;
    out_last_r       <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_rank           = out_rank_r;
  assign out_entry_score    = out_score_r;
  assign out_entry_initials = out_init_r;
  assign out_slot_valid     = out_slot_valid_r;
  assign out_last           = out_last_r;

endmodule

>>> verif/sorted_score_table_top_test.sv
// ----------------------------------------------------------------------------
// sorted_score_table_top_test
// Self-checking bench for the sorted score table. Requests go in through the
// valid/stall channel, and a behavioral copy of the table works out the 16
// slot reports that each dump should return. A checker compares every report
// field by field. Both sides idle at random, with some stretches that do not
// idle at all.
// ----------------------------------------------------------------------------
module sorted_score_table_top_test;
  import sst_pkg::*;

  localparam int MAX_CYCLES    = 400000;
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;
  localparam int RANDOM_ITEMS  = 410;

  typedef struct {
    logic [RANK_W-1:0]         rank;
    logic signed [SCORE_W-1:0] score;
    logic [INIT_W-1:0]         initials;
    logic                      slot_valid;
    logic                      slot_last;
  } slot_report_t;

  logic                      clk         = 1'b0;
  logic                      rst_n       = 1'b0;
  logic                      in_valid    = 1'b0;
  logic                      in_stall;
  logic [MODE_W-1:0]         in_mode     = MODE_INSERT;
  logic signed [SCORE_W-1:0] in_score    = '0;
  logic [INIT_W-1:0]         in_initials = '0;
  logic                      out_valid;
  logic                      out_stall   = 1'b0;
  logic [RANK_W-1:0]         out_rank;
  logic signed [SCORE_W-1:0] out_entry_score;
  logic [INIT_W-1:0]         out_entry_initials;
  logic                      out_slot_valid;
  logic                      out_last;

  // Behavioral copy of the table.
  logic signed [SCORE_W-1:0] board_score    [CAPACITY];
  logic [INIT_W-1:0]         board_initials [CAPACITY];
  int                        board_count = 0;
  slot_report_t              pending_slots [$];

  int errors        = 0;
  int cycles        = 0;
  int requests_sent = 0;
  int stall_hold    = 0;
  bit quiet         = 1'b0;

  sorted_score_table_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_score           (in_score),
    .in_initials        (in_initials),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_rank           (out_rank),
    .out_entry_score    (out_entry_score),
    .out_entry_initials (out_entry_initials),
    .out_slot_valid     (out_slot_valid),
    .out_last           (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("sorted_score_table_top_test NOT OK");
      $finish;
    end
  end

  function automatic int draw_wait();
    return quiet ? 0 : int'($urandom_range(0, 6));
  endfunction

  // A new entry goes below every entry with an equal or greater score.
  function automatic void board_insert(logic signed [SCORE_W-1:0] sc,
                                       logic [INIT_W-1:0] ini);
    int pos;
    int k;
    pos = 0;
    while (pos < board_count && board_score[pos] >= sc) pos++;
    if (pos >= CAPACITY) return;
    k = (board_count < CAPACITY) ? board_count : CAPACITY - 1;
    while (k > pos) begin
      board_score[k]    = board_score[k-1];
      board_initials[k] = board_initials[k-1];
      k--;
    end
    board_score[pos]    = sc;
    board_initials[pos] = ini & NAME_MASK;
    if (board_count < CAPACITY) board_count++;
  endfunction

  function automatic void board_dump();
    slot_report_t r;
    int k;
    for (k = 0; k < CAPACITY; k++) begin
      r.rank       = RANK_W'(k);
      r.slot_valid = (k < board_count);
      r.score      = r.slot_valid ? board_score[k] : '0;
      r.initials   = r.slot_valid ? board_initials[k] : '0;
      r.slot_last  = (k == CAPACITY - 1);
      pending_slots.insert(pending_slots.size(), r);
    end
  endfunction

  function automatic void predict_request(mode_t m, logic signed [SCORE_W-1:0] sc,
                                          logic [INIT_W-1:0] ini);
    case (m)
      MODE_INSERT: board_insert(sc, ini);
      MODE_CLEAR:  board_count = 0;
      MODE_DUMP:   board_dump();
      default: ;
    endcase
  endfunction

  function automatic void compare_field(string field, logic [RANK_W-1:0] rank,
                                        logic [63:0] expected, logic [63:0] actual);
    if (expected !== actual) begin
      errors++;
      $display("%0t: rank %0d %s expected %0h actual %0h",
               $time, rank, field, expected, actual);
    end
  endfunction

  // Dump report checker and receiver stall generator.
  always @(posedge clk) begin
    slot_report_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_slots.size() == 0) begin
          errors++;
          $display("%0t: unexpected dump report, expected none, actual rank %0d",
                   $time, out_rank);
        end else begin
          want = pending_slots.pop_front();
          compare_field("rank", want.rank, 64'(want.rank), 64'(out_rank));
          compare_field("entry_score", want.rank, 64'(want.score), 64'(out_entry_score));
          compare_field("entry_initials", want.rank, 64'(want.initials),
                        64'(out_entry_initials));
          compare_field("slot_valid", want.rank, 64'(want.slot_valid),
                        64'(out_slot_valid));
          compare_field("last", want.rank, 64'(want.slot_last), 64'(out_last));
        end
        stall_hold = draw_wait();
      end else if (stall_hold > 0) begin
        stall_hold--;
      end
      out_stall <= (stall_hold != 0);
    end
  end

  // Holds the request until it is taken. in_valid is lowered only when a gap
  // follows, so back-to-back requests keep it high.
  task automatic send_request(mode_t m, logic signed [SCORE_W-1:0] sc,
                              logic [INIT_W-1:0] ini);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= m;
    in_score    <= sc;
    in_initials <= ini;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(m, sc, ini);
    requests_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SCORE_W-1:0] pick_score(int style);
    int v;
    case (style)
      0: begin
        v = int'($urandom_range(0, 8)) - 4;
        return v;
      end
      1: return $urandom();
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return '0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  task automatic test_empty_dump();
    send_request(MODE_DUMP, '0, '0);
    wait_for_results();
  endtask

  // Extremes of score and initials, and equal scores that must keep arrival order.
  task automatic test_extremes_and_ties();
    send_request(MODE_INSERT, 32'sd0, 24'h414141);
    send_request(MODE_INSERT, 32'sh7fffffff, 24'hffffff);
    send_request(MODE_INSERT, 32'sh80000000, 24'h000000);
    send_request(MODE_INSERT, -32'sd1, 24'h5a5a5a);
    send_request(MODE_INSERT, 32'sd0, 24'h424242);
    send_request(MODE_INSERT, 32'sh7fffffff, 24'h123456);
    send_request(MODE_INSERT, 32'sd1, 24'ha5a5a5);
    send_request(MODE_DUMP, '0, '0);
    wait_for_results();
  endtask

  task automatic test_unused_mode();
    send_request(MODE_NONE, 32'sh5555aaaa, 24'haa55aa);
    send_request(MODE_DUMP, '0, '0);
    wait_for_results();
  endtask

  task automatic test_clear();
    send_request(MODE_CLEAR, '0, '0);
    send_request(MODE_DUMP, '0, '0);
    send_request(MODE_INSERT, 32'sd42, 24'h4a4b4c);
    send_request(MODE_DUMP, '0, '0);
    wait_for_results();
  endtask

  // Sessions of inserts that often overfill the table, with dumps in between,
  // stray clears and unused-mode noise.
  task automatic test_random_sessions();
    int start;
    int n;
    int style;
    int i;
    int session;
    start   = requests_sent;
    session = 0;
    while (requests_sent - start < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 4) == 0);
      style = $urandom_range(0, 2);
      n     = $urandom_range(0, 24);
      if ($urandom_range(0, 1) == 0) begin
        send_request(MODE_CLEAR, $urandom(), INIT_W'($urandom()));
      end
      for (i = 0; i < n; i++) begin
        case ($urandom_range(0, 15))
          0: send_request(MODE_DUMP, $urandom(), INIT_W'($urandom()));
          1: send_request(MODE_NONE, $urandom(), INIT_W'($urandom()));
          2: begin
            if ($urandom_range(0, 3) == 0) begin
              send_request(MODE_CLEAR, $urandom(), INIT_W'($urandom()));
            end else begin
              send_request(MODE_INSERT, pick_score(style), INIT_W'($urandom()));
            end
          end
          default: send_request(MODE_INSERT, pick_score(style), INIT_W'($urandom()));
        endcase
      end
      send_request(MODE_DUMP, $urandom(), INIT_W'($urandom()));
      session++;
      if (session % 5 == 0) wait_for_results();
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_dump();
    test_extremes_and_ties();
    test_unused_mode();
    test_clear();
    test_random_sessions();
    wait_for_results();
    if (errors == 0) begin
      $display("sorted_score_table_top_test OK");
    end else begin
      $display("sorted_score_table_top_test NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/sst_pkg.sv
hw/rtl/sst_ram.sv
hw/rtl/sorted_score_table_top.sv
verif/sorted_score_table_top_test.sv
